[hw/rtl/wum_pkg.sv]
// Shared types, constants and the cup volume lookup function of the water usage meter.
package wum_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_EVAL = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_ACC  = 8'b0001_0000,
        ST_MOD  = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_STER_A   = 3'd0,
        CFG_STER_B   = 3'd1,
        CFG_MAX_FIRST  = 3'd2,
        CFG_MAX_SECOND = 3'd3,
        CFG_MAX_THIRD  = 3'd4
    } cfg_idx_t;

    // Water kind codes.
    localparam logic [1:0] KIND_PURE = 2'd0;
    localparam logic [1:0] KIND_COLD = 2'd1;

    // Sterilisation phase codes.
    localparam logic [3:0] PH_PREPARE  = 4'd1;
    localparam logic [3:0] PH_HOT      = 4'd2;
    localparam logic [3:0] PH_LUKEWARM = 4'd3;
    localparam logic [3:0] PH_FINAL    = 4'd4;
    localparam logic [3:0] PH_TRAYPREP = 4'd5;
    localparam logic [3:0] PH_TRAY     = 4'd6;
    localparam logic [3:0] PH_MELTPREP = 4'd7;
    localparam logic [3:0] PH_MELT     = 4'd8;

    // Event flag bit positions.
    localparam int FL_PREPARE  = 0;
    localparam int FL_HOT      = 1;
    localparam int FL_LUKEWARM = 2;
    localparam int FL_FINAL    = 3;
    localparam int FL_TRAY     = 4;
    localparam int FL_MELT     = 5;
    localparam int FL_FILL     = 6;
    localparam int FL_DRAIN    = 7;

    // Last step index of each serial operation of the shared arithmetic.
    localparam logic [4:0] MUL_LAST = 5'd15;
    localparam logic [4:0] DIV_LAST = 5'd27;
    localparam logic [4:0] MOD_LAST = 5'd18;

    localparam logic [11:0] ML_PER_LITRE = 12'd1000;
    localparam logic [9:0]  ML_PER_LITRE_M1 = 10'd999;

    // Cup volume in millilitres for the current selection.
    function automatic logic [11:0] cup_ml(input logic cont, input logic [1:0] kind,
                                           input logic [2:0] level);
        logic [11:0] ml;
        if (cont) begin
            if (kind == KIND_PURE)
                ml = 12'd2100;
            else if (kind == KIND_COLD)
                ml = 12'd2200;
            else
                ml = 12'd2000;
        end else begin
            case (level)
                3'd0:    ml = 12'd120;
                3'd1:    ml = 12'd175;
                3'd2:    ml = 12'd235;
                3'd3:    ml = 12'd295;
                3'd4:    ml = 12'd355;
                3'd5:    ml = 12'd415;
                3'd6:    ml = 12'd475;
                default: ml = 12'd590;
            endcase
        end
        return ml;
    endfunction

endpackage

[hw/rtl/water_usage_meter_core.sv]
// Bit-serial meter: a dispense that ends with a nonzero planned time runs the 16-step multiply
// and the 28-step divide by the planned time, every enabled word runs the 19-step divide by
// 1000, and a word with metering disabled skips them all. in_stall holds off a new input word
// until the sequencer is back in idle; a new word is taken while the previous result word waits.
// Reset (rst_n low, asynchronous) clears all counters, latches and event flags, sets the
// litre limits to 65535 and the sterilisation volumes to zero.
module water_usage_meter_core
    import wum_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        metering_enabled,
    input  logic        dispensing,
    input  logic        continuous_mode,
    input  logic [1:0]  water_kind,
    input  logic [2:0]  cup_level,
    input  logic [15:0] planned_ticks,
    input  logic        ice_tray_filling,
    input  logic        drain_active,
    input  logic        ster_active,
    input  logic [3:0]  ster_phase,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        dispense_done,
    output logic [15:0] dispensed_ml,
    output logic [15:0] first_filter_liters,
    output logic [15:0] second_filter_liters,
    output logic [15:0] third_filter_liters,
    output logic [9:0]  pending_ml,
    // Configuration port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers.
    logic [63:0] ster_a_reg;
    logic [63:0] ster_b_reg;
    logic [15:0] max_reg [3];

    // Sequencer.
    state_t      state_reg;
    state_t      state_next;
    logic [4:0]  step_reg;

    // Captured input word.
    logic        it_en_reg;
    logic        it_disp_reg;
    logic        it_cont_reg;
    logic [1:0]  it_kind_reg;
    logic [2:0]  it_cup_reg;
    logic [15:0] it_planned_reg;
    logic        it_fill_reg;
    logic        it_drain_reg;
    logic        it_ster_reg;
    logic [3:0]  it_phase_reg;

    // Meter state.
    logic [15:0] tick_cnt_reg;
    logic [15:0] lat_planned_reg;
    logic [11:0] lat_cup_reg;
    logic [9:0]  rem_reg;
    logic [15:0] litres_reg [3];
    logic [7:0]  flags_reg;
    logic [15:0] last_ml_reg;
    logic        done_reg;

    // Serial arithmetic registers.
    logic [27:0] work_reg;
    logic [15:0] div_rem_reg;
    logic [18:0] ev_sum_reg;
    logic [18:0] acc_reg;
    logic [9:0]  rem1k_reg;

    // Output word register.
    logic        out_valid_reg;
    logic        done_out_reg;
    logic [15:0] ml_out_reg;
    logic [15:0] litres_out_reg [3];
    logic [9:0]  pend_out_reg;

    logic        in_take;
    logic        out_free;
    logic [15:0] tick_inc;
    logic [7:0]  flags_next;
    logic [18:0] ev_add;
    logic [12:0] mul_sum;
    logic [17:0] div_diff;
    logic [11:0] mod_diff;
    logic [15:0] quot_sat;
    logic [16:0] litre_sum [3];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign tick_inc = (tick_cnt_reg != 16'hFFFF) ? tick_cnt_reg + 16'd1 : tick_cnt_reg;

    // Event flags and the volumes that rising events add, on top of the remainder.
    always_comb
    begin
        flags_next = flags_reg;
        ev_add     = {9'd0, rem_reg};
        if (it_fill_reg)
        begin
            if (!flags_reg[FL_FILL])
            begin
                flags_next[FL_FILL] = 1'b1;
                ev_add = ev_add + {3'd0, ster_b_reg[47:32]};
            end
        end
        else
        begin
            flags_next[FL_FILL] = 1'b0;
        end
        if (it_drain_reg)
        begin
            if (!flags_reg[FL_DRAIN])
            begin
                flags_next[FL_DRAIN] = 1'b1;
                ev_add = ev_add + {3'd0, ster_b_reg[63:48]};
            end
        end
        else
        begin
            flags_next[FL_DRAIN] = 1'b0;
        end
        if (it_ster_reg)
        begin
            case (it_phase_reg)
                PH_PREPARE:
                    if (!flags_reg[FL_PREPARE])
                    begin
                        flags_next[FL_PREPARE] = 1'b1;
                        ev_add = ev_add + {3'd0, ster_a_reg[15:0]};
                    end
                PH_HOT:
                    if (!flags_reg[FL_HOT])
                    begin
                        flags_next[FL_HOT] = 1'b1;
                        ev_add = ev_add + {3'd0, ster_a_reg[31:16]};
                    end
                PH_LUKEWARM:
                    if (!flags_reg[FL_LUKEWARM])
                    begin
                        flags_next[FL_LUKEWARM] = 1'b1;
                        ev_add = ev_add + {3'd0, ster_a_reg[47:32]};
                    end
                PH_FINAL:
                    if (!flags_reg[FL_FINAL])
                    begin
                        flags_next[FL_FINAL] = 1'b1;
                        ev_add = ev_add + {3'd0, ster_a_reg[63:48]};
                    end
                PH_TRAYPREP:
                    flags_next[FL_TRAY] = 1'b0;
                PH_TRAY:
                    if (!flags_reg[FL_TRAY])
                    begin
                        flags_next[FL_TRAY] = 1'b1;
                        ev_add = ev_add + {3'd0, ster_b_reg[15:0]};
                    end
                PH_MELTPREP:
                    flags_next[FL_MELT] = 1'b0;
                PH_MELT:
                    if (!flags_reg[FL_MELT])
                    begin
                        flags_next[FL_MELT] = 1'b1;
                        ev_add = ev_add + {3'd0, ster_b_reg[31:16]};
                    end
                default:
                    flags_next = flags_next;
            endcase
        end
        else
        begin
            flags_next = flags_next & 8'hC0;
        end
    end

    // Step logic of the serial multiply, divide and divide by 1000.
    assign mul_sum  = {1'b0, work_reg[27:16]} + (work_reg[0] ? {1'b0, lat_cup_reg} : 13'd0);
    assign div_diff = {1'b0, div_rem_reg, work_reg[27]} - {2'b00, lat_planned_reg};
    assign mod_diff = {1'b0, rem1k_reg, acc_reg[18]} - ML_PER_LITRE;
    assign quot_sat = (work_reg[27:16] != 12'd0) ? 16'hFFFF : work_reg[15:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            litre_sum[i] = {1'b0, litres_reg[i]} + {8'd0, acc_reg[8:0]};
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_EVAL;
            ST_EVAL:
                if (!it_en_reg)
                    state_next = ST_OUT;
                else if (!it_disp_reg && tick_cnt_reg != 16'd0 && lat_planned_reg != 16'd0)
                    state_next = ST_MUL;
                else
                    state_next = ST_ACC;
            ST_MUL:  if (step_reg == MUL_LAST) state_next = ST_DIV;
            ST_DIV:  if (step_reg == DIV_LAST) state_next = ST_ACC;
            ST_ACC:  state_next = ST_MOD;
            ST_MOD:  if (step_reg == MOD_LAST) state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ster_a_reg <= '0;
            ster_b_reg <= '0;
            for (int i = 0; i < 3; i++)
                max_reg[i] <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STER_A:     ster_a_reg <= cfg_data;
                CFG_STER_B:     ster_b_reg <= cfg_data;
                CFG_MAX_FIRST:  max_reg[0] <= cfg_data[15:0];
                CFG_MAX_SECOND: max_reg[1] <= cfg_data[15:0];
                CFG_MAX_THIRD:  max_reg[2] <= cfg_data[15:0];
                default:        ster_a_reg <= ster_a_reg;
            endcase
        end
    end

    // Capture of the input word.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            it_en_reg      <= metering_enabled;
            it_disp_reg    <= dispensing;
            it_cont_reg    <= continuous_mode;
            it_kind_reg    <= water_kind;
            it_cup_reg     <= cup_level;
            it_planned_reg <= planned_ticks;
            it_fill_reg    <= ice_tray_filling;
            it_drain_reg   <= drain_active;
            it_ster_reg    <= ster_active;
            it_phase_reg   <= ster_phase;
        end
    end

    // Serial datapath registers.
    // With no planned time the dispense skips the multiply and divide, so the work
    // register is cleared and the sum in ST_ACC adds nothing for it.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_EVAL:
            begin
                ev_sum_reg  <= ev_add;
                div_rem_reg <= '0;
                work_reg    <= (lat_planned_reg != 16'd0) ? {12'd0, tick_inc} : 28'd0;
            end
            ST_MUL:
                work_reg <= {mul_sum, work_reg[15:1]};
            ST_DIV:
            begin
                if (!div_diff[17])
                begin
                    div_rem_reg <= div_diff[15:0];
                    work_reg    <= {work_reg[26:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= {div_rem_reg[14:0], work_reg[27]};
                    work_reg    <= {work_reg[26:0], 1'b0};
                end
            end
            ST_ACC:
            begin
                acc_reg   <= ev_sum_reg + (done_reg ? {3'd0, quot_sat} : 19'd0);
                rem1k_reg <= '0;
            end
            ST_MOD:
            begin
                if (!mod_diff[11])
                begin
                    rem1k_reg <= mod_diff[9:0];
                    acc_reg   <= {acc_reg[17:0], 1'b1};
                end
                else
                begin
                    rem1k_reg <= {rem1k_reg[8:0], acc_reg[18]};
                    acc_reg   <= {acc_reg[17:0], 1'b0};
                end
            end
            default:
                work_reg <= work_reg;
        endcase
    end

    // Sequencer, meter state and output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            tick_cnt_reg    <= '0;
            lat_planned_reg <= '0;
            lat_cup_reg     <= '0;
            rem_reg         <= '0;
            flags_reg       <= '0;
            last_ml_reg     <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
                litres_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                step_reg <= '0;
            else
                step_reg <= step_reg + 5'd1;

            // The output register fills as a word leaves ST_OUT and empties when taken.
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_EVAL:
                begin
                    done_reg <= 1'b0;
                    if (it_en_reg)
                    begin
                        flags_reg <= flags_next;
                        if (it_disp_reg)
                        begin
                            tick_cnt_reg    <= tick_inc;
                            lat_planned_reg <= it_planned_reg;
                            lat_cup_reg     <= cup_ml(it_cont_reg, it_kind_reg, it_cup_reg);
                        end
                        else if (tick_cnt_reg != 16'd0)
                        begin
                            tick_cnt_reg <= '0;
                            done_reg     <= 1'b1;
                        end
                        else
                        begin
                            lat_planned_reg <= '0;
                            lat_cup_reg     <= '0;
                        end
                    end
                end
                ST_ACC:
                    if (done_reg)
                        last_ml_reg <= (lat_planned_reg != 16'd0) ? quot_sat : 16'd0;
                ST_UPD:
                begin
                    rem_reg <= rem1k_reg;
                    if (acc_reg[8:0] != 9'd0)
                    begin
                        for (int i = 0; i < 3; i++)
                            litres_reg[i] <= (litre_sum[i] >= {1'b0, max_reg[i]}) ?
                                             max_reg[i] : litre_sum[i][15:0];
                    end
                end
                default:
                    done_reg <= done_reg;
            endcase
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            done_out_reg <= done_reg;
            ml_out_reg   <= last_ml_reg;
            pend_out_reg <= rem_reg;
            for (int i = 0; i < 3; i++)
                litres_out_reg[i] <= litres_reg[i];
        end
    end

    assign out_valid            = out_valid_reg;
    assign dispense_done        = done_out_reg;
    assign dispensed_ml         = ml_out_reg;
    assign first_filter_liters  = litres_out_reg[0];
    assign second_filter_liters = litres_out_reg[1];
    assign third_filter_liters  = litres_out_reg[2];
    assign pending_ml           = pend_out_reg;

    // The carried remainder always stays below one litre.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= ML_PER_LITRE_M1)
        else $error("pending remainder reached 1000 ml");

    // The partial remainder of the divide by 1000 stays below the divisor.
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (rem1k_reg <= ML_PER_LITRE_M1))
        else $error("divide by 1000 partial remainder out of range");

    // The partial remainder of the volume divide stays below the planned time.
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_rem_reg < lat_planned_reg))
        else $error("volume divide partial remainder out of range");

    // After a carry every litre counter sits at or below its limit.
    a_litre_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && acc_reg[8:0] != 9'd0) |=>
        (litres_reg[0] <= max_reg[0] && litres_reg[1] <= max_reg[1] &&
         litres_reg[2] <= max_reg[2]))
        else $error("litre counter above its limit after a carry");

    // A finished word reaches the output register and the sequencer is free again.
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result word not handed to the output register");

endmodule

[test/testbench.sv]
// Self-checking testbench of the water usage meter core with a predicting scoreboard.
`timescale 1ns / 100ps

module testbench
    import wum_pkg::*;
();

    localparam logic [3:0] PH_OTHER = 4'd0;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 200;
    localparam int REPORT_LIMIT = 10;

    // One control tick as it goes into the block.
    typedef struct {
        logic        enabled;
        logic        dispensing;
        logic        continuous;
        logic [1:0]  kind;
        logic [2:0]  cup;
        logic [15:0] planned;
        logic        fill;
        logic        drain;
        logic        ster;
        logic [3:0]  phase;
    } tick_t;

    // One meter reading as it comes out of the block.
    typedef struct {
        logic        done;
        logic [15:0] ml;
        logic [15:0] first;
        logic [15:0] second;
        logic [15:0] third;
        logic [9:0]  pending;
    } reading_t;

    // Tracks the meter state and the readings still owed by the block.
    class usage_ledger;
        logic [63:0] ster_vols_a;
        logic [63:0] ster_vols_b;
        logic [15:0] litre_limit [3];
        logic [15:0] tick_count;
        logic [15:0] planned_latch;
        logic [11:0] cup_latch;
        logic [9:0]  remainder;
        logic [15:0] litres [3];
        logic [7:0]  done_flags;
        logic [15:0] last_ml;
        reading_t    readings [$];
        int          mismatches;

        function new();
            ster_vols_a = '0;
            ster_vols_b = '0;
            tick_count = '0;
            planned_latch = '0;
            cup_latch = '0;
            remainder = '0;
            done_flags = '0;
            last_ml = '0;
            mismatches = 0;
            for (int i = 0; i < 3; i++)
            begin
                litre_limit[i] = 16'hFFFF;
                litres[i] = '0;
            end
        endfunction

        function void set_register(cfg_idx_t idx, logic [63:0] value);
            case (idx)
                CFG_STER_A:     ster_vols_a = value;
                CFG_STER_B:     ster_vols_b = value;
                CFG_MAX_FIRST:  litre_limit[0] = value[15:0];
                CFG_MAX_SECOND: litre_limit[1] = value[15:0];
                CFG_MAX_THIRD:  litre_limit[2] = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] slot(logic [63:0] word64, int n);
            return word64[16 * n +: 16];
        endfunction

        // Adds millilitres and carries whole litres into the saturating counters.
        function void credit_ml(int unsigned ml);
            int unsigned sum;
            int unsigned whole;
            int unsigned c;
            sum = remainder + ml;
            if (sum >= ML_PER_LITRE)
            begin
                whole = sum / ML_PER_LITRE;
                remainder = 10'(sum % ML_PER_LITRE);
                for (int i = 0; i < 3; i++)
                begin
                    c = litres[i] + whole;
                    if (c >= litre_limit[i])
                        c = litre_limit[i];
                    litres[i] = c[15:0];
                end
            end
            else
            begin
                remainder = sum[9:0];
            end
        endfunction

        // Credits a volume once per rising condition; a low condition rearms it.
        function void once(logic cond, int bit_pos, logic [15:0] ml);
            if (cond)
            begin
                if (!done_flags[bit_pos])
                begin
                    done_flags[bit_pos] = 1'b1;
                    credit_ml(ml);
                end
            end
            else
            begin
                done_flags[bit_pos] = 1'b0;
            end
        endfunction

        function logic [11:0] cup_volume(tick_t t);
            if (t.continuous)
            begin
                if (t.kind == KIND_PURE)
                    return 12'd2100;
                else if (t.kind == KIND_COLD)
                    return 12'd2200;
                return 12'd2000;
            end
            case (t.cup)
                3'd0:    return 12'd120;
                3'd1:    return 12'd175;
                3'd2:    return 12'd235;
                3'd3:    return 12'd295;
                3'd4:    return 12'd355;
                3'd5:    return 12'd415;
                3'd6:    return 12'd475;
                default: return 12'd590;
            endcase
        endfunction

        // Advances the meter by one accepted word and queues the reading it owes.
        function void log_tick(tick_t t);
            reading_t    r;
            int unsigned span;
            int unsigned vol;
            r.done = 1'b0;
            if (t.enabled)
            begin
                if (t.dispensing)
                begin
                    if (tick_count != 16'hFFFF)
                        tick_count++;
                    planned_latch = t.planned;
                    cup_latch = cup_volume(t);
                end
                else if (tick_count != 0)
                begin
                    span = tick_count;
                    if (span < 16'hFFFF)
                        span++;
                    vol = 0;
                    if (planned_latch != 0)
                        vol = (span * cup_latch) / planned_latch;
                    if (vol > 16'hFFFF)
                        vol = 16'hFFFF;
                    credit_ml(vol);
                    last_ml = vol[15:0];
                    tick_count = '0;
                    r.done = 1'b1;
                end
                else
                begin
                    planned_latch = '0;
                    cup_latch = '0;
                end

                once(t.fill, FL_FILL, slot(ster_vols_b, 2));
                once(t.drain, FL_DRAIN, slot(ster_vols_b, 3));

                if (t.ster)
                begin
                    case (t.phase)
                        PH_PREPARE:  once(1'b1, FL_PREPARE, slot(ster_vols_a, 0));
                        PH_HOT:      once(1'b1, FL_HOT, slot(ster_vols_a, 1));
                        PH_LUKEWARM: once(1'b1, FL_LUKEWARM, slot(ster_vols_a, 2));
                        PH_FINAL:    once(1'b1, FL_FINAL, slot(ster_vols_a, 3));
                        PH_TRAYPREP: done_flags[FL_TRAY] = 1'b0;
                        PH_TRAY:     once(1'b1, FL_TRAY, slot(ster_vols_b, 0));
                        PH_MELTPREP: done_flags[FL_MELT] = 1'b0;
                        PH_MELT:     once(1'b1, FL_MELT, slot(ster_vols_b, 1));
                        default: ;
                    endcase
                end
                else
                begin
                    // Leaving sterilisation rearms its phases but not tray fill or drain.
                    for (int i = FL_PREPARE; i <= FL_MELT; i++)
                        done_flags[i] = 1'b0;
                end
            end
            r.ml = last_ml;
            r.first = litres[0];
            r.second = litres[1];
            r.third = litres[2];
            r.pending = remainder;
            readings.push_back(r);
        endfunction

        // Compares a reading from the block with the oldest one owed.
        function void match_reading(reading_t got);
            reading_t want;
            if (readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: reading with no word pending: done=%0d ml=%0d",
                             $realtime, got.done, got.ml);
                return;
            end
            want = readings.pop_front();
            if (got.done !== want.done || got.ml !== want.ml || got.first !== want.first ||
                got.second !== want.second || got.third !== want.third ||
                got.pending !== want.pending)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: expected done=%0d ml=%0d litres=%0d/%0d/%0d pending=%0d",
                             $realtime, want.done, want.ml, want.first, want.second,
                             want.third, want.pending);
                    $display("%0t: actual   done=%0d ml=%0d litres=%0d/%0d/%0d pending=%0d",
                             $realtime, got.done, got.ml, got.first, got.second,
                             got.third, got.pending);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        metering_enabled = 1'b0;
    logic        dispensing = 1'b0;
    logic        continuous_mode = 1'b0;
    logic [1:0]  water_kind = '0;
    logic [2:0]  cup_level = '0;
    logic [15:0] planned_ticks = '0;
    logic        ice_tray_filling = 1'b0;
    logic        drain_active = 1'b0;
    logic        ster_active = 1'b0;
    logic [3:0]  ster_phase = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        dispense_done;
    logic [15:0] dispensed_ml;
    logic [15:0] first_filter_liters;
    logic [15:0] second_filter_liters;
    logic [15:0] third_filter_liters;
    logic [9:0]  pending_ml;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    usage_ledger ledger;
    bit          sender_quiet;
    bit          receiver_quiet;
    int          hold_left;
    int          quiet_cycles;

    // State of the well-formed random sequences.
    int          disp_left;
    logic        run_cont;
    logic [1:0]  run_kind;
    logic [2:0]  run_cup;
    logic [15:0] run_planned;
    logic        fill_state;
    logic        drain_state;
    int          ster_step;

    water_usage_meter_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: take a word when valid and not stalled, then draw the next stall.
    always @(posedge clk)
    begin
        reading_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.done = dispense_done;
            got.ml = dispensed_ml;
            got.first = first_filter_liters;
            got.second = second_filter_liters;
            got.third = third_filter_liters;
            got.pending = pending_ml;
            ledger.match_reading(got);
            hold_left = receiver_quiet ? 0 : $urandom_range(0, 19);
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("water_usage_meter_core test failed");
                $finish;
            end
        end
    end

    // Enabled tick with nothing going on.
    function automatic tick_t idle_tick();
        tick_t t;
        t.enabled = 1'b1;
        t.dispensing = 1'b0;
        t.continuous = 1'b0;
        t.kind = KIND_PURE;
        t.cup = '0;
        t.planned = '0;
        t.fill = 1'b0;
        t.drain = 1'b0;
        t.ster = 1'b0;
        t.phase = PH_OTHER;
        return t;
    endfunction

    function automatic logic [15:0] pick_volume();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 2500));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 60));
        endcase
    endfunction

    // Mostly dispense runs, tray and drain events and sterilisation programmes; some noise.
    function automatic tick_t next_tick();
        tick_t t;
        if ($urandom_range(0, 11) == 0)
        begin
            t.enabled = 1'($urandom_range(0, 1));
            t.dispensing = 1'($urandom_range(0, 1));
            t.continuous = 1'($urandom_range(0, 1));
            t.kind = 2'($urandom_range(0, 3));
            t.cup = 3'($urandom_range(0, 7));
            t.planned = 16'($urandom_range(0, 65535));
            t.fill = 1'($urandom_range(0, 1));
            t.drain = 1'($urandom_range(0, 1));
            t.ster = 1'($urandom_range(0, 1));
            t.phase = 4'($urandom_range(0, 15));
            return t;
        end

        // Start a new dispense with its own cup selection and planned time.
        if (disp_left == 0 && $urandom_range(0, 3) == 0)
        begin
            disp_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
                                                    : $urandom_range(1, 8);
            run_cont = ($urandom_range(0, 2) == 0);
            run_kind = 2'($urandom_range(0, 3));
            run_cup = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       run_planned = 16'd0;
                1:       run_planned = 16'd1;
                2:       run_planned = 16'($urandom_range(0, 65535));
                default: run_planned = 16'($urandom_range(2, 40));
            endcase
        end
        t.enabled = ($urandom_range(0, 19) != 0);
        t.dispensing = (disp_left != 0);
        if (t.enabled && disp_left != 0)
            disp_left--;
        t.continuous = run_cont;
        t.kind = run_kind;
        t.cup = run_cup;
        t.planned = run_planned;
        if ($urandom_range(0, 7) == 0)
        begin
            t.cup = 3'($urandom_range(0, 7));
            t.kind = 2'($urandom_range(0, 3));
            t.planned = 16'($urandom_range(1, 60));
        end

        if ($urandom_range(0, 7) == 0)
            fill_state = !fill_state;
        if ($urandom_range(0, 9) == 0)
            drain_state = !drain_state;
        t.fill = fill_state;
        t.drain = drain_state;

        // Sterilisation walks its phases in order, now and then aborting.
        if (ster_step == 0)
        begin
            if ($urandom_range(0, 24) == 0)
                ster_step = 1;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            ster_step = 0;
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            ster_step = (ster_step >= 8) ? 0 : ster_step + 1;
        end
        t.ster = (ster_step != 0);
        t.phase = (ster_step != 0) ? 4'(ster_step) : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0)
            t.phase = ($urandom_range(0, 1) == 0) ? PH_OTHER : 4'($urandom_range(9, 15));
        return t;
    endfunction

    // Presents one word after a random gap and holds it until taken.
    task automatic send_tick(tick_t t);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        metering_enabled = t.enabled;
        dispensing = t.dispensing;
        continuous_mode = t.continuous;
        water_kind = t.kind;
        cup_level = t.cup;
        planned_ticks = t.planned;
        ice_tray_filling = t.fill;
        drain_active = t.drain;
        ster_active = t.ster;
        ster_phase = t.phase;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        ledger.log_tick(t);
    endtask

    // Stops sending and waits until every owed reading has arrived.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (ledger.readings.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_register(cfg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        ledger.set_register(idx, value);
    endtask

    task automatic load_settings(logic [63:0] vols_a, logic [63:0] vols_b,
                                 logic [15:0] lim1, logic [15:0] lim2, logic [15:0] lim3);
        settle();
        program_register(CFG_STER_A, vols_a);
        program_register(CFG_STER_B, vols_b);
        program_register(CFG_MAX_FIRST, {48'd0, lim1});
        program_register(CFG_MAX_SECOND, {48'd0, lim2});
        program_register(CFG_MAX_THIRD, {48'd0, lim3});
    endtask

    initial
    begin
        tick_t t;
        ledger = new();
        hold_left = 0;
        quiet_cycles = 0;
        disp_left = 0;
        ster_step = 0;
        fill_state = 1'b0;
        drain_state = 1'b0;
        run_cont = 1'b0;
        run_kind = KIND_PURE;
        run_cup = '0;
        run_planned = '0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Metering disabled with every input asserted: nothing may change.
        t = idle_tick();
        t.enabled = 1'b0;
        t.dispensing = 1'b1;
        t.continuous = 1'b1;
        t.kind = 2'b11;
        t.cup = 3'b111;
        t.planned = 16'hFFFF;
        t.fill = 1'b1;
        t.drain = 1'b1;
        t.ster = 1'b1;
        t.phase = PH_PREPARE;
        send_tick(t);
        // A quiet tick with no dispense running clears the latches.
        send_tick(idle_tick());

        load_settings({16'hFFFF, 16'd1, 16'd999, 16'd0}, {16'd250, 16'hFFFF, 16'd1000, 16'd1500},
                      16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Continuous dispense of water kind three, ending on no planned time,
        // while sterilisation walks through every phase.
        for (int p = 0; p <= 8; p++)
        begin
            t = idle_tick();
            t.dispensing = 1'b1;
            t.continuous = 1'b1;
            t.kind = 2'b11;
            t.cup = 3'(p);
            t.planned = (p == 8) ? 16'd0 : 16'(p * 7 + 1);
            t.ster = 1'b1;
            t.phase = 4'(p);
            send_tick(t);
        end
        // Dispense ends; a phase above eight does nothing; tray fill and drain rise.
        t = idle_tick();
        t.ster = 1'b1;
        t.phase = 4'hF;
        t.fill = 1'b1;
        t.drain = 1'b1;
        send_tick(t);
        // A repeated phase credits nothing; drain falls and rearms.
        t = idle_tick();
        t.ster = 1'b1;
        t.phase = PH_HOT;
        t.fill = 1'b1;
        send_tick(t);
        // Sterilisation ends: the phase flags clear, the tray fill flag stays.
        t = idle_tick();
        t.fill = 1'b1;
        send_tick(t);

        // The first two limits lowered below the counts: the next carry clamps to them.
        load_settings({16'hFFFF, 16'd1, 16'd999, 16'd0}, {16'd250, 16'hFFFF, 16'd1000, 16'd1500},
                      16'd0, 16'd5, 16'hFFFF);
        send_tick(idle_tick());
        t = idle_tick();
        t.fill = 1'b1;
        send_tick(t);

        // Random phases, each under its own settings and idling pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                load_settings('0, '0, 16'd0, 16'd0, 16'd0);
            else if (ph == 1)
                load_settings('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
                load_settings({pick_volume(), pick_volume(), pick_volume(), pick_volume()},
                              {pick_volume(), pick_volume(), pick_volume(), pick_volume()},
                              pick_limit(), pick_limit(), pick_limit());
            sender_quiet = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            repeat (TICKS_PER_PHASE)
                send_tick(next_tick());
        end

        // Long dispenses at full rate.
        load_settings({pick_volume(), pick_volume(), pick_volume(), pick_volume()},
                      {pick_volume(), pick_volume(), pick_volume(), pick_volume()},
                      16'hFFFF, pick_limit(), 16'hFFFF);
        sender_quiet = 1'b1;
        receiver_quiet = 1'b1;
        // Cold continuous water over one planned tick: the volume saturates.
        t = idle_tick();
        t.dispensing = 1'b1;
        t.continuous = 1'b1;
        t.kind = KIND_COLD;
        t.planned = 16'd1;
        repeat (30) send_tick(t);
        send_tick(idle_tick());
        // A long dispense of the largest cup over the longest planned time.
        t.continuous = 1'b0;
        t.cup = 3'd7;
        t.planned = 16'hFFFF;
        repeat (60) send_tick(t);
        send_tick(idle_tick());

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.readings.size() == 0)
            $display("water_usage_meter_core test passed");
        else
            $display("water_usage_meter_core test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/wum_pkg.sv
hw/rtl/water_usage_meter_core.sv
test/testbench.sv
